FILE: src/qapd_pkg.sv
`timescale 1ns / 1ps

package qapd_pkg;

  // Field widths
  localparam int ANG_W  = 16;
  localparam int RATE_W = 16;
  localparam int GAIN_W = 16;
  localparam int THR_W  = 16;
  localparam int CNT_W  = 16;

  // Wrapped angle error, products, PD terms and motor sums
  localparam int ERR_W  = ANG_W + 1;
  localparam int PROD_W = GAIN_W + 1 + ERR_W;   // 17 x 17 signed product
  localparam int P_W    = PROD_W + 3;           // room for the rate term shift
  localparam int TERM_W = P_W + 5;              // sum of two, times ten
  localparam int BASE_W = THR_W + CNT_W + 5;    // thrust * period, Q.21
  localparam int SUM_W  = TERM_W + 2;

  localparam int FRAC_BITS = 21;
  localparam int D_SHIFT   = 3;

  // Angle wrap limits, Q2.13
  localparam logic signed [ERR_W-1:0] ANG_PI     = 17'sd25736;
  localparam logic signed [ERR_W-1:0] ANG_TWO_PI = 17'sd51472;

  // Yaw rate magnitude at or below which recovery counts as done, Q5.10
  localparam logic signed [RATE_W-1:0] RATE_RECOVERED_MAX = 16'sd179;

  // Thrust below this level shuts the motors off, Q0.16
  localparam logic [THR_W-1:0] THRUST_SHUTOFF = 16'd1311;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P_YAW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D_YAW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TUMBLE_YAW = 3'd4;

  // Proportional and damping products of one axis, both Q.21
  typedef struct packed {
    logic signed [P_W-1:0] p;
    logic signed [P_W-1:0] d;
  } qapd_axis_t;

endpackage

FILE: src/quad_attitude_pd_mixer_core.sv
`timescale 1ns / 1ps
// The result passes through the input, product and result registers in turn.
// Throughput: one item per cycle while out_stall_i stays low; each stage advances when the next one is free.
// The stage after the gain multipliers sets the cycle time.
// Reset (async, active low) clears stage valids, gains and the recovery state.
// Configuration writes are always ready.

module quad_attitude_pd_mixer_core
  import qapd_pkg::*;
#(
  parameter int PWM_PERIOD = 36000
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [GAIN_W-1:0]        cfg_data_i,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [THR_W-1:0]         des_thrust_i,
  input  logic signed [ANG_W-1:0]  des_roll_i,
  input  logic signed [ANG_W-1:0]  des_pitch_i,
  input  logic signed [ANG_W-1:0]  des_yaw_i,
  input  logic signed [ANG_W-1:0]  meas_roll_i,
  input  logic signed [ANG_W-1:0]  meas_pitch_i,
  input  logic signed [ANG_W-1:0]  meas_yaw_i,
  input  logic signed [RATE_W-1:0] rate_x_i,
  input  logic signed [RATE_W-1:0] rate_y_i,
  input  logic signed [RATE_W-1:0] rate_z_i,
  input  logic                     recovery_request_i,
  input  logic                     motors_enable_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CNT_W-1:0]         motor_a_o,
  output logic [CNT_W-1:0]         motor_b_o,
  output logic [CNT_W-1:0]         motor_c_o,
  output logic [CNT_W-1:0]         motor_d_o,
  output logic                     recovered_flag_o,
  output logic                     driving_o
);

  localparam logic [CNT_W-1:0] PERIOD_C = CNT_W'(PWM_PERIOD);

  // gains
  logic [GAIN_W-1:0] gain_p_q, gain_d_q, gain_p_yaw_q, gain_d_yaw_q, gain_tumble_yaw_q;

  // recovery state
  logic recovered_q, recovered_d;
  logic prev_rec_q;
  logic rate_small;

  // stage 0: captured item
  logic                     s0_valid_q;
  logic [THR_W-1:0]         s0_thrust_q;
  logic signed [ANG_W-1:0]  s0_des_roll_q, s0_des_pitch_q, s0_des_yaw_q;
  logic signed [ANG_W-1:0]  s0_meas_roll_q, s0_meas_pitch_q, s0_meas_yaw_q;
  logic signed [RATE_W-1:0] s0_rate_x_q, s0_rate_y_q, s0_rate_z_q;
  logic                     s0_rec_q, s0_en_q, s0_recov_q;

  // stage 1: products
  logic              s1_valid_q;
  qapd_axis_t        s1_roll_q, s1_pitch_q, s1_yaw_q;
  qapd_axis_t        roll_d, pitch_d, yaw_d;
  logic [BASE_W-1:0] s1_base_q, base_d;
  logic              s1_drive_q, s1_recov_q;
  logic [GAIN_W-1:0] kp_yaw, kd_yaw;

  // stage 2: result
  logic                   out_valid_q;
  logic [3:0][CNT_W-1:0]  motor_d, motor_q;
  logic                   recov_q, drive_q;

  logic ready2, ready1, ready0, in_xfer;

  // Stage handshakes: a stage takes new data when empty or when it moves on
  assign ready2     = !out_valid_q || !out_stall_i;
  assign ready1     = !s1_valid_q || ready2;
  assign ready0     = !s0_valid_q || ready1;
  assign in_stall_o = !ready0;
  assign in_xfer    = in_valid_i && ready0;

  // Configuration writes; unknown indexes drop
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q          <= '0;
      gain_d_q          <= '0;
      gain_p_yaw_q      <= '0;
      gain_d_yaw_q      <= '0;
      gain_tumble_yaw_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GAIN_P:          gain_p_q          <= cfg_data_i;
        CFG_GAIN_D:          gain_d_q          <= cfg_data_i;
        CFG_GAIN_P_YAW:      gain_p_yaw_q      <= cfg_data_i;
        CFG_GAIN_D_YAW:      gain_d_yaw_q      <= cfg_data_i;
        CFG_GAIN_TUMBLE_YAW: gain_tumble_yaw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Recovery flag: clear on entry to recovery, set when yaw rate is small
  assign rate_small = (rate_z_i <= RATE_RECOVERED_MAX) && (rate_z_i >= -RATE_RECOVERED_MAX);

  always_comb begin
    if (recovery_request_i) begin
      recovered_d = (recovered_q && prev_rec_q) || rate_small;
    end else begin
      recovered_d = recovered_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recovered_q <= 1'b0;
      prev_rec_q  <= 1'b0;
    end else if (in_xfer) begin
      recovered_q <= recovered_d;
      prev_rec_q  <= recovery_request_i;
    end
  end

  // Stage 0: capture the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (ready0) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s0_thrust_q     <= des_thrust_i;
      s0_des_roll_q   <= des_roll_i;
      s0_des_pitch_q  <= des_pitch_i;
      s0_des_yaw_q    <= des_yaw_i;
      s0_meas_roll_q  <= meas_roll_i;
      s0_meas_pitch_q <= meas_pitch_i;
      s0_meas_yaw_q   <= meas_yaw_i;
      s0_rate_x_q     <= rate_x_i;
      s0_rate_y_q     <= rate_y_i;
      s0_rate_z_q     <= rate_z_i;
      s0_rec_q        <= recovery_request_i;
      s0_en_q         <= motors_enable_i;
      s0_recov_q      <= recovered_d;
    end
  end

  // Stage 1: wrap errors and form gain products
  assign kp_yaw = s0_rec_q ? '0 : gain_p_yaw_q;
  assign kd_yaw = s0_rec_q ? gain_tumble_yaw_q : gain_d_yaw_q;

  qapd_axis u_roll (
    .des_i  (s0_des_roll_q),
    .meas_i (s0_meas_roll_q),
    .rate_i (s0_rate_x_q),
    .kp_i   (gain_p_q),
    .kd_i   (gain_d_q),
    .prod_o (roll_d)
  );

  qapd_axis u_pitch (
    .des_i  (s0_des_pitch_q),
    .meas_i (s0_meas_pitch_q),
    .rate_i (s0_rate_y_q),
    .kp_i   (gain_p_q),
    .kd_i   (gain_d_q),
    .prod_o (pitch_d)
  );

  qapd_axis u_yaw (
    .des_i  (s0_des_yaw_q),
    .meas_i (s0_meas_yaw_q),
    .rate_i (s0_rate_z_q),
    .kp_i   (kp_yaw),
    .kd_i   (kd_yaw),
    .prod_o (yaw_d)
  );

  assign base_d = (BASE_W'(s0_thrust_q) * BASE_W'(PERIOD_C)) << 5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ready1) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && s0_valid_q) begin
      s1_roll_q  <= roll_d;
      s1_pitch_q <= pitch_d;
      s1_yaw_q   <= yaw_d;
      s1_base_q  <= base_d;
      s1_drive_q <= s0_en_q && (s0_thrust_q >= THRUST_SHUTOFF);
      s1_recov_q <= s0_recov_q;
    end
  end

  // Stage 2: mix, clamp and hold the result
  qapd_mix #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_mix (
    .roll_i  (s1_roll_q),
    .pitch_i (s1_pitch_q),
    .yaw_i   (s1_yaw_q),
    .base_i  (s1_base_q),
    .drive_i (s1_drive_q),
    .motor_o (motor_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready2) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && s1_valid_q) begin
      motor_q <= motor_d;
      recov_q <= s1_recov_q;
      drive_q <= s1_drive_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign motor_a_o        = motor_q[0];
  assign motor_b_o        = motor_q[1];
  assign motor_c_o        = motor_q[2];
  assign motor_d_o        = motor_q[3];
  assign recovered_flag_o = recov_q;
  assign driving_o        = drive_q;

endmodule

FILE: src/qapd_axis.sv
`timescale 1ns / 1ps

module qapd_axis
  import qapd_pkg::*;
(
  input  logic signed [ANG_W-1:0]  des_i,
  input  logic signed [ANG_W-1:0]  meas_i,
  input  logic signed [RATE_W-1:0] rate_i,
  input  logic        [GAIN_W-1:0] kp_i,
  input  logic        [GAIN_W-1:0] kd_i,
  output qapd_axis_t               prod_o
);

  logic signed [ERR_W-1:0]  diff;
  logic signed [ERR_W-1:0]  err;
  logic signed [RATE_W:0]   neg_rate;
  logic signed [GAIN_W:0]   kp_s;
  logic signed [GAIN_W:0]   kd_s;
  logic signed [PROD_W-1:0] p_full;
  logic signed [PROD_W-1:0] d_full;

  // Form the error and wrap it into (-pi, pi]; one step always suffices
  assign diff = {des_i[ANG_W-1], des_i} - {meas_i[ANG_W-1], meas_i};

  always_comb begin
    if (diff <= -ANG_PI) begin
      err = diff + ANG_TWO_PI;
    end else if (diff > ANG_PI) begin
      err = diff - ANG_TWO_PI;
    end else begin
      err = diff;
    end
  end

  // Gain products: Kp*e in Q.21, Kd*(-w) in Q.18 moved up to Q.21
  assign neg_rate = -{rate_i[RATE_W-1], rate_i};
  assign kp_s     = $signed({1'b0, kp_i});
  assign kd_s     = $signed({1'b0, kd_i});
  assign p_full   = kp_s * err;
  assign d_full   = kd_s * neg_rate;

  assign prod_o.p = P_W'(p_full);
  assign prod_o.d = P_W'(d_full) <<< D_SHIFT;

endmodule

FILE: src/qapd_mix.sv
`timescale 1ns / 1ps

module qapd_mix
  import qapd_pkg::*;
#(
  parameter int PWM_PERIOD = 36000
) (
  input  qapd_axis_t              roll_i,
  input  qapd_axis_t              pitch_i,
  input  qapd_axis_t              yaw_i,
  input  logic [BASE_W-1:0]       base_i,
  input  logic                    drive_i,
  output logic [3:0][CNT_W-1:0]   motor_o
);

  localparam logic [CNT_W-1:0] PERIOD_C = CNT_W'(PWM_PERIOD);
  localparam logic signed [SUM_W-1:0] TOP = $signed(SUM_W'(PERIOD_C)) <<< FRAC_BITS;

  logic signed [P_W:0]       s_roll;
  logic signed [P_W:0]       s_pitch;
  logic signed [P_W:0]       s_yaw;
  logic signed [SUM_W-1:0]   t_roll;
  logic signed [SUM_W-1:0]   t_pitch;
  logic signed [SUM_W-1:0]   t_yaw;
  logic signed [SUM_W-1:0]   base_s;
  logic signed [SUM_W-1:0]   sum [4];

  // PD sums times ten: 8x + 2x
  assign s_roll  = (P_W+1)'(roll_i.p)  + (P_W+1)'(roll_i.d);
  assign s_pitch = (P_W+1)'(pitch_i.p) + (P_W+1)'(pitch_i.d);
  assign s_yaw   = (P_W+1)'(yaw_i.p)   + (P_W+1)'(yaw_i.d);

  assign t_roll  = (SUM_W'(s_roll)  <<< 3) + (SUM_W'(s_roll)  <<< 1);
  assign t_pitch = (SUM_W'(s_pitch) <<< 3) + (SUM_W'(s_pitch) <<< 1);
  assign t_yaw   = (SUM_W'(s_yaw)   <<< 3) + (SUM_W'(s_yaw)   <<< 1);

  assign base_s = $signed({{(SUM_W-BASE_W){1'b0}}, base_i});

  // X mixer
  assign sum[0] = base_s - t_pitch + t_yaw;
  assign sum[1] = base_s + t_roll  - t_yaw;
  assign sum[2] = base_s + t_pitch + t_yaw;
  assign sum[3] = base_s - t_roll  - t_yaw;

  // Clamp each sum to 0..period, drop the fraction, zero when shut off
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!drive_i || sum[i] < 0) begin
        motor_o[i] = '0;
      end else if (sum[i] > TOP) begin
        motor_o[i] = PERIOD_C;
      end else begin
        motor_o[i] = sum[i][FRAC_BITS +: CNT_W];
      end
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import qapd_pkg::*;
();

  localparam int PWM_PERIOD      = 36000;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int TAIL_CYCLES     = 8;
  localparam int N_GAINS         = CFG_GAIN_TUMBLE_YAW + 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(CFG_GAIN_TUMBLE_YAW + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = {CFG_IDX_W{1'b1}};

  // One attitude command as it enters the block
  typedef struct packed {
    logic [THR_W-1:0]         thrust;
    logic signed [ANG_W-1:0]  d_roll;
    logic signed [ANG_W-1:0]  d_pitch;
    logic signed [ANG_W-1:0]  d_yaw;
    logic signed [ANG_W-1:0]  m_roll;
    logic signed [ANG_W-1:0]  m_pitch;
    logic signed [ANG_W-1:0]  m_yaw;
    logic signed [RATE_W-1:0] w_x;
    logic signed [RATE_W-1:0] w_y;
    logic signed [RATE_W-1:0] w_z;
    logic                     rec;
    logic                     en;
  } att_cmd_t;

  // Motor counts and flags as they leave the block
  typedef struct packed {
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
    logic [CNT_W-1:0] c;
    logic [CNT_W-1:0] d;
    logic             rec_flag;
    logic             drive;
  } motor_cmd_t;

  typedef enum logic [1:0] {ROW_CMD, ROW_TYPED, ROW_GAINS} row_kind_e;

  typedef struct packed {
    row_kind_e                       kind;
    att_cmd_t                        cmd;
    motor_cmd_t                      res;
    logic [N_GAINS-1:0][GAIN_W-1:0]  gains;
  } dir_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [GAIN_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  att_cmd_t                 in_cmd = '0;
  logic                     out_stall = 1'b0;
  logic                     cfg_ready_o;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [CNT_W-1:0]         motor_a_o, motor_b_o, motor_c_o, motor_d_o;
  logic                     recovered_flag_o;
  logic                     driving_o;

  // Predictor state and gains
  logic [GAIN_W-1:0] k_p = '0, k_d = '0, k_py = '0, k_dy = '0, k_tumble = '0;
  logic              recovered = 1'b0;
  logic              prev_rec = 1'b0;

  motor_cmd_t motor_due_q[$];
  dir_row_t   dir_tab[$];
  int         sender_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         n_errors = 0;
  int         cycle_cnt = 0;
  logic       rec_level = 1'b0;
  motor_cmd_t mon_want, mon_got;

  quad_attitude_pd_mixer_core #(
    .PWM_PERIOD(PWM_PERIOD)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .des_thrust_i       (in_cmd.thrust),
    .des_roll_i         (in_cmd.d_roll),
    .des_pitch_i        (in_cmd.d_pitch),
    .des_yaw_i          (in_cmd.d_yaw),
    .meas_roll_i        (in_cmd.m_roll),
    .meas_pitch_i       (in_cmd.m_pitch),
    .meas_yaw_i         (in_cmd.m_yaw),
    .rate_x_i           (in_cmd.w_x),
    .rate_y_i           (in_cmd.w_y),
    .rate_z_i           (in_cmd.w_z),
    .recovery_request_i (in_cmd.rec),
    .motors_enable_i    (in_cmd.en),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .motor_a_o          (motor_a_o),
    .motor_b_o          (motor_b_o),
    .motor_c_o          (motor_c_o),
    .motor_d_o          (motor_d_o),
    .recovered_flag_o   (recovered_flag_o),
    .driving_o          (driving_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Wrap an angle error into (-pi, pi]
  function automatic longint wrap_angle(longint e);
    if (e <= -longint'(ANG_PI)) return e + longint'(ANG_TWO_PI);
    if (e > longint'(ANG_PI)) return e - longint'(ANG_TWO_PI);
    return e;
  endfunction

  // Ten times the PD term of one axis, Q.21
  function automatic longint pd_counts(logic [GAIN_W-1:0] kp, longint e,
                                       logic [GAIN_W-1:0] kd, logic signed [RATE_W-1:0] w);
    longint p, dmp;
    p   = longint'(kp) * e;
    dmp = (longint'(kd) * (-longint'($signed(w)))) <<< D_SHIFT;
    return (p + dmp) * 10;
  endfunction

  // Clamp a Q.21 motor sum to 0..period and drop the fraction
  function automatic logic [CNT_W-1:0] clamp_count(longint v);
    longint top;
    top = longint'(PWM_PERIOD) <<< FRAC_BITS;
    if (v > top) return CNT_W'(PWM_PERIOD);
    if (v < 0) return '0;
    return CNT_W'(v >>> FRAC_BITS);
  endfunction

  // Advance the recovery state and mix one command into motor counts
  function automatic motor_cmd_t mix_motors(att_cmd_t c);
    longint er, ep, ey, tr, tp, ty, base;
    motor_cmd_t r;
    er = wrap_angle(longint'($signed(c.d_roll)) - longint'($signed(c.m_roll)));
    ep = wrap_angle(longint'($signed(c.d_pitch)) - longint'($signed(c.m_pitch)));
    ey = wrap_angle(longint'($signed(c.d_yaw)) - longint'($signed(c.m_yaw)));
    if (c.rec && !prev_rec) recovered = 1'b0;
    prev_rec = c.rec;
    tr = pd_counts(k_p, er, k_d, c.w_x);
    tp = pd_counts(k_p, ep, k_d, c.w_y);
    if (c.rec) begin
      ty = pd_counts('0, 0, k_tumble, c.w_z);
      if (longint'($signed(c.w_z)) <= longint'(RATE_RECOVERED_MAX) &&
          longint'($signed(c.w_z)) >= -longint'(RATE_RECOVERED_MAX))
        recovered = 1'b1;
    end else begin
      ty = pd_counts(k_py, ey, k_dy, c.w_z);
    end
    base = (longint'(c.thrust) * PWM_PERIOD) <<< (FRAC_BITS - THR_W);
    r.drive = c.en && (c.thrust >= THRUST_SHUTOFF);
    if (r.drive) begin
      r.a = clamp_count(base - tp + ty);
      r.b = clamp_count(base + tr - ty);
      r.c = clamp_count(base + tp + ty);
      r.d = clamp_count(base - tr - ty);
    end else begin
      r.a = '0;
      r.b = '0;
      r.c = '0;
      r.d = '0;
    end
    r.rec_flag = recovered;
    return r;
  endfunction

  function automatic att_cmd_t mk_cmd(int thr, int dr, int dp, int dy, int mr, int mp,
                                      int my, int wx, int wy, int wz, bit rec, bit en);
    att_cmd_t c;
    c.thrust  = THR_W'(thr);
    c.d_roll  = ANG_W'(dr);
    c.d_pitch = ANG_W'(dp);
    c.d_yaw   = ANG_W'(dy);
    c.m_roll  = ANG_W'(mr);
    c.m_pitch = ANG_W'(mp);
    c.m_yaw   = ANG_W'(my);
    c.w_x     = RATE_W'(wx);
    c.w_y     = RATE_W'(wy);
    c.w_z     = RATE_W'(wz);
    c.rec     = rec;
    c.en      = en;
    return c;
  endfunction

  function automatic motor_cmd_t mk_res(int m, bit rf, bit drv);
    motor_cmd_t r;
    r.a = CNT_W'(m);
    r.b = CNT_W'(m);
    r.c = CNT_W'(m);
    r.d = CNT_W'(m);
    r.rec_flag = rf;
    r.drive = drv;
    return r;
  endfunction

  function automatic void add_row(row_kind_e kind, att_cmd_t c, motor_cmd_t r);
    dir_row_t row;
    row = '0;
    row.kind = kind;
    row.cmd = c;
    row.res = r;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_gains(int gp, int gd, int gpy, int gdy, int gt);
    dir_row_t row;
    row = '0;
    row.kind = ROW_GAINS;
    row.gains[CFG_GAIN_P]          = GAIN_W'(gp);
    row.gains[CFG_GAIN_D]          = GAIN_W'(gd);
    row.gains[CFG_GAIN_P_YAW]      = GAIN_W'(gpy);
    row.gains[CFG_GAIN_D_YAW]      = GAIN_W'(gdy);
    row.gains[CFG_GAIN_TUMBLE_YAW] = GAIN_W'(gt);
    dir_tab.push_back(row);
  endfunction

  function automatic logic signed [ANG_W-1:0] rand_angle();
    case ($urandom_range(9))
      0:       return -ANG_W'(25736);
      1:       return ANG_W'(25736);
      2:       return '0;
      default: return ANG_W'(int'($urandom_range(51472)) - 25736);
    endcase
  endfunction

  function automatic logic signed [RATE_W-1:0] rand_rate();
    case ($urandom_range(9))
      0:       return RATE_W'(-32768);
      1:       return RATE_W'(32767);
      2, 3:    return RATE_W'(int'($urandom_range(360)) - 180);
      4:       return RATE_W'($urandom);
      default: return RATE_W'(int'($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic logic [THR_W-1:0] rand_thrust();
    case ($urandom_range(11))
      0:       return THRUST_SHUTOFF - 1'b1;
      1:       return THRUST_SHUTOFF;
      2:       return '0;
      3:       return '1;
      default: return THR_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(1023));
    endcase
  endfunction

  // Recovery requests come in runs so that entry and exit edges both occur
  function automatic att_cmd_t rand_cmd();
    att_cmd_t c;
    if ($urandom_range(7) == 0) rec_level = ~rec_level;
    c.thrust  = rand_thrust();
    c.d_roll  = rand_angle();
    c.d_pitch = rand_angle();
    c.d_yaw   = rand_angle();
    c.m_roll  = rand_angle();
    c.m_pitch = rand_angle();
    c.m_yaw   = rand_angle();
    c.w_x     = rand_rate();
    c.w_y     = rand_rate();
    c.w_z     = rand_rate();
    c.rec     = rec_level;
    c.en      = ($urandom_range(9) != 0);
    return c;
  endfunction

  // Drop valid and hold until every pending result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (motor_due_q.size() != 0) @(posedge clk_i);
  endtask

  // Transfer one register write; valid stays high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_GAIN_P:          k_p = val;
      CFG_GAIN_D:          k_d = val;
      CFG_GAIN_P_YAW:      k_py = val;
      CFG_GAIN_D_YAW:      k_dy = val;
      CFG_GAIN_TUMBLE_YAW: k_tumble = val;
      default:             ;
    endcase
  endtask

  // Write all gains plus one unused index, which must be ignored
  task automatic write_gains(input logic [N_GAINS-1:0][GAIN_W-1:0] g);
    for (int i = 0; i < N_GAINS; i++) begin
      write_reg(CFG_IDX_W'(i), g[i]);
      if (i == 1)
        write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                  GAIN_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // Offer one command, wait for its transfer, then record its result
  task automatic send_cmd(input att_cmd_t c, input logic typed, input motor_cmd_t typed_res);
    motor_cmd_t p;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_cmd   <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = mix_motors(c);
    motor_due_q.push_back(typed ? typed_res : p);
  endtask

  task automatic report(input string tag, input motor_cmd_t want, input motor_cmd_t got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%s: want a=%0d b=%0d c=%0d d=%0d rec=%0b drv=%0b",
               tag, want.a, want.b, want.c, want.d, want.rec_flag, want.drive);
      $display("  got a=%0d b=%0d c=%0d d=%0d rec=%0b drv=%0b",
               got.a, got.b, got.c, got.d, got.rec_flag, got.drive);
    end
  endtask

  // Receiver stalls
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Compare each result transfer against the oldest pending prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      mon_got = {motor_a_o, motor_b_o, motor_c_o, motor_d_o, recovered_flag_o, driving_o};
      if (motor_due_q.size() == 0) begin
        report("unexpected result", '0, mon_got);
      end else begin
        mon_want = motor_due_q.pop_front();
        if (mon_got !== mon_want) report("result mismatch", mon_want, mon_got);
      end
    end
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [N_GAINS-1:0][GAIN_W-1:0] g;

    // Reset gains: thrust alone sets the counts
    add_row(ROW_TYPED, mk_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), mk_res(0, 0, 0));
    add_row(ROW_TYPED, mk_cmd(65535, 25736, -25736, 25736, -25736, 25736, -25736,
                              -32768, 32767, -32768, 0, 0), mk_res(0, 0, 0));
    add_row(ROW_TYPED, mk_cmd(65535, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), mk_res(35999, 0, 1));
    add_row(ROW_TYPED, mk_cmd(1310, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), mk_res(0, 0, 0));
    add_row(ROW_TYPED, mk_cmd(1311, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), mk_res(720, 0, 1));
    // Distinct gain values per register: wraps, rates, recovery edges
    add_gains(256, 128, 384, 64, 512);
    add_row(ROW_CMD, mk_cmd(32768, 0, 0, 0, 25736, 0, 0, 0, 0, 0, 0, 1), '0);
    add_row(ROW_CMD, mk_cmd(32768, 25736, -25736, 0, -25736, 25736, 0, 0, 0, 0, 0, 1), '0);
    add_row(ROW_CMD, mk_cmd(32768, 0, 25736, 25736, 0, -1, 0, 0, 0, 0, 0, 1), '0);
    add_row(ROW_CMD, mk_cmd(32768, 0, 0, -25736, 0, 0, 0, 0, 0, 0, 0, 1), '0);
    add_row(ROW_CMD, mk_cmd(40000, 0, 0, 0, 0, 0, 0, -32768, 32767, -32768, 0, 1), '0);
    add_row(ROW_CMD, mk_cmd(40000, 0, 0, 0, 0, 0, 0, 32767, -32768, 32767, 0, 1), '0);
    add_row(ROW_CMD, mk_cmd(40000, 100, -100, 200, 0, 0, 0, 50, -50, 179, 1, 1), '0);
    add_row(ROW_CMD, mk_cmd(40000, 100, -100, 200, 0, 0, 0, 50, -50, 5000, 1, 1), '0);
    add_row(ROW_CMD, mk_cmd(40000, 100, -100, 200, 0, 0, 0, 50, -50, 5000, 0, 1), '0);
    add_row(ROW_CMD, mk_cmd(40000, 100, -100, 200, 0, 0, 0, 50, -50, 180, 1, 1), '0);
    add_row(ROW_CMD, mk_cmd(40000, 100, -100, 200, 0, 0, 0, 50, -50, -179, 1, 1), '0);
    add_row(ROW_CMD, mk_cmd(40000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), '0);
    add_row(ROW_CMD, mk_cmd(40000, 0, 0, 0, 0, 0, 0, 0, 0, -180, 1, 1), '0);
    // Full-scale gains: clamp at both ends
    add_gains(65535, 65535, 65535, 65535, 65535);
    add_row(ROW_CMD, mk_cmd(65535, 25736, -25736, 25736, 0, 0, 0,
                            -32768, 32767, -32768, 0, 1), '0);
    add_row(ROW_CMD, mk_cmd(1311, -25735, 25735, -25735, 0, 0, 0,
                            32767, -32768, 32767, 0, 1), '0);
    add_row(ROW_CMD, mk_cmd(65535, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), '0);
    add_row(ROW_CMD, mk_cmd(65535, 0, 0, 0, 0, 0, 0, 0, 0, -32768, 1, 1), '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    sender_idle_pct = 19;
    rx_stall_pct = 19;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_GAINS) begin
        drain();
        write_gains(dir_tab[i].gains);
      end else begin
        send_cmd(dir_tab[i].cmd, dir_tab[i].kind == ROW_TYPED, dir_tab[i].res);
      end
    end

    // Random phases, each with its own gains and one of four idling patterns
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      for (int i = 0; i < N_GAINS; i++) begin
        if (ph == 0) g[i] = '1;
        else if (ph == 1) g[i] = '0;
        else g[i] = rand_gain();
      end
      write_gains(g);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin sender_idle_pct = 85; rx_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rx_stall_pct = 85; end
        default: begin sender_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) drain();
        send_cmd(rand_cmd(), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && motor_due_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/qapd_pkg.sv
src/qapd_axis.sv
src/qapd_mix.sv
src/quad_attitude_pd_mixer_core.sv
sim/tb_top.sv
